// ===== src/sfd_pkg.sv =====
// shared types and constants for the stream frame decoder
package sfd_pkg;

  // header layout, byte offsets within the frame body
  localparam int unsigned IdEnd     = 8;
  localparam int unsigned TimeEnd   = 16;
  localparam int unsigned SeqEnd    = 20;
  localparam int unsigned HdrBytes  = 24;
  localparam int unsigned TrlBytes  = 8;
  localparam int unsigned MinFrame  = HdrBytes + TrlBytes;

  localparam logic [7:0]  MarkChar  = 8'h5A;  // 'Z'
  localparam logic [7:0]  DropMask  = 8'hF8;
  localparam logic [7:0]  TypeMask  = 8'h07;
  localparam int unsigned DropShift = 13;
  localparam logic [15:0] PosTop    = 16'hFFFF;

  localparam int unsigned BatchDataMaxDefault = 4096;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_MARK = 2'd3
  } sfd_status_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } sfd_in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    sfd_status_e status;
    logic [63:0] frame_id;
    logic [63:0] time_stamp;
    logic [31:0] seq_number;
    logic [31:0] payload_length;
    logic [20:0] dropped_count;
    logic [7:0]  batch_frames;
    logic [2:0]  last_type;
  } sfd_out_t;

endpackage

// ===== src/sfd_decode.sv =====
// frame decode state and per-beat result logic
module sfd_decode
  import sfd_pkg::*;
#(
  parameter int unsigned BatchDataMax = BatchDataMaxDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  sfd_in_t  beat_i,
  output sfd_out_t result_o
);

  localparam logic [31:0] LenMax = 32'(BatchDataMax);

  logic [15:0] pos_q, pos_d;
  logic [63:0] id_q, id_d, id_nx;
  logic [63:0] time_q, time_d, time_nx;
  logic [31:0] seq_q, seq_d, seq_nx;
  logic [31:0] len_q, len_d, len_nx;
  logic [15:0] drop_q, drop_d, drop_nx;
  logic [7:0]  frames_q, frames_d, frames_nx;
  logic [7:0]  flags_q, flags_d, flags_nx;
  logic        mark_q, mark_d, mark_nx;

  logic [7:0]  b;
  logic [32:0] win_end;
  logic [32:0] pos_wide;
  logic [32:0] t_off;
  logic        in_win;
  logic [16:0] count;
  logic        too_short;
  logic        len_bad;
  sfd_status_e status;

  assign b        = beat_i.body_byte;
  assign pos_wide = {17'd0, pos_q};
  assign win_end  = {1'b0, len_q} + 33'(HdrBytes);
  assign in_win   = pos_wide < win_end;
  assign t_off    = pos_wide - win_end;

  always_comb begin
    id_nx     = id_q;
    time_nx   = time_q;
    seq_nx    = seq_q;
    len_nx    = len_q;
    drop_nx   = drop_q;
    frames_nx = frames_q;
    flags_nx  = flags_q;
    mark_nx   = mark_q;
    if (pos_q < 16'(IdEnd)) begin
      id_nx = {id_q[55:0], b};
    end else if (pos_q < 16'(TimeEnd)) begin
      time_nx = {time_q[55:0], b};
    end else if (pos_q < 16'(SeqEnd)) begin
      seq_nx = {seq_q[23:0], b};
    end else if (pos_q < 16'(HdrBytes)) begin
      len_nx = {len_q[23:0], b};
    end else if (!in_win) begin
      // trailer bytes, offset from the end of the payload window
      if (t_off < 33'd2) begin
        drop_nx = {drop_q[7:0], b};
      end else if (t_off == 33'd2) begin
        frames_nx = b;
      end else if (t_off == 33'd3) begin
        flags_nx = b;
      end else if (t_off < 33'(TrlBytes)) begin
        if (b != MarkChar) begin
          mark_nx = 1'b0;
        end
      end
    end
  end

  // status is judged on the state including this beat
  assign count     = {1'b0, pos_q} + 17'd1;
  assign too_short = count < 17'(MinFrame);
  assign len_bad   = (len_nx > LenMax) ||
                     ({16'd0, count} != ({1'b0, len_nx} + 33'(MinFrame)));

  always_comb begin
    if (too_short) begin
      status = ST_SHORT;
    end else if (len_bad) begin
      status = ST_BAD_LEN;
    end else if (!mark_nx) begin
      status = ST_BAD_MARK;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result_o               = '0;
    result_o.payload_valid = (pos_q >= 16'(HdrBytes)) && in_win;
    result_o.payload_byte  = b;
    result_o.status        = ST_OK;
    if (beat_i.last_byte) begin
      result_o.frame_done = 1'b1;
      result_o.status     = status;
      if (status == ST_OK) begin
        result_o.frame_id       = id_nx;
        result_o.time_stamp     = time_nx;
        result_o.seq_number     = seq_nx;
        result_o.payload_length = len_nx;
        result_o.dropped_count  = {5'd0, drop_nx} |
                                  (21'(flags_nx & DropMask) << DropShift);
        result_o.batch_frames   = frames_nx;
        result_o.last_type      = 3'(flags_nx & TypeMask);
      end
    end
  end

  // clear for the next frame after the last beat
  always_comb begin
    if (beat_i.last_byte) begin
      pos_d    = '0;
      id_d     = '0;
      time_d   = '0;
      seq_d    = '0;
      len_d    = '0;
      drop_d   = '0;
      frames_d = '0;
      flags_d  = '0;
      mark_d   = 1'b1;
    end else begin
      pos_d    = (pos_q < PosTop) ? pos_q + 16'd1 : pos_q;
      id_d     = id_nx;
      time_d   = time_nx;
      seq_d    = seq_nx;
      len_d    = len_nx;
      drop_d   = drop_nx;
      frames_d = frames_nx;
      flags_d  = flags_nx;
      mark_d   = mark_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      id_q     <= '0;
      time_q   <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      drop_q   <= '0;
      frames_q <= '0;
      flags_q  <= '0;
      mark_q   <= 1'b1;
    end else if (step_i) begin
      pos_q    <= pos_d;
      id_q     <= id_d;
      time_q   <= time_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      drop_q   <= drop_d;
      frames_q <= frames_d;
      flags_q  <= flags_d;
      mark_q   <= mark_d;
    end
  end

endmodule

// ===== src/stream_frame_decoder.sv =====
// top level of the stream frame decoder: input and result registers around the decode
//
// usage
//   in channel: one frame body byte per beat, last_byte set on the final byte.
//   out channel: one result beat per input beat, in order. payload_valid marks
//   bytes inside the declared payload window; on the last byte frame_done is
//   set and status plus the decoded header and trailer fields follow (fields
//   are zero unless status is ok).
//   path: a taken beat is registered in the input register, passes through the
//   decode into the result register once that slot is free, and is offered on
//   out_valid_o from there.
//   throughput: one beat per cycle while out_stall_i is low; the decode is
//   a position compare and field capture between the input and result registers.
//   out stall: the result register holds; the input register still takes one
//   more beat, then in_stall_o rises until the result is taken.
//   reset: both registers empty, position zero, marker flag set, so the next
//   byte is taken as byte zero of a new frame.
module stream_frame_decoder
  import sfd_pkg::*;
#(
  parameter int unsigned BatchDataMax = BatchDataMaxDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sfd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sfd_out_t out_data_o
);

  // input register
  logic     in_vld_q, in_vld_d;
  sfd_in_t  in_beat_q;
  // result register
  logic     res_vld_q, res_vld_d;
  sfd_out_t res_q;
  sfd_out_t result;

  logic res_free;
  logic advance;
  logic in_free;
  logic take;

  // result slot frees when empty or being taken this cycle
  assign res_free   = !res_vld_q || !out_stall_i;
  assign advance    = in_vld_q && res_free;
  assign in_free    = !in_vld_q || res_free;
  assign take       = in_valid_i && in_free;
  assign in_stall_o = !in_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  // decode state moves only when a beat passes into the result register
  sfd_decode #(
    .BatchDataMax(BatchDataMax)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .beat_i  (in_beat_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_beat_q <= in_data_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

// ===== tb/tb_stream_frame_decoder.sv =====
// self-checking testbench for stream_frame_decoder with a bytewise frame predictor
`timescale 1ns / 1ps

module tb_stream_frame_decoder;
  import sfd_pkg::*;

  localparam int unsigned BATCH_MAX   = BatchDataMaxDefault;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned SHOW_MAX    = 10;

  // directed rows: typed rows carry an expectation read straight off the frame rules
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    sfd_status_e st;
  } dir_row_t;

  localparam int unsigned DIR_N = 23;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'hFF, 1'b1, 1'b1, ST_SHORT}, '{8'h00, 1'b1, 1'b1, ST_SHORT},
    '{8'h5A, 1'b1, 1'b1, ST_SHORT},
    // twenty byte body of extremes, ends inside the header
    '{8'hFF, 1'b0, 1'b0, ST_OK},    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, ST_OK},    '{8'h01, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h5A, 1'b0, 1'b0, ST_OK},    '{8'hA5, 1'b0, 1'b0, ST_OK},
    '{8'h7F, 1'b0, 1'b0, ST_OK},    '{8'hFE, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h55, 1'b0, 1'b0, ST_OK},    '{8'hAA, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},    '{8'h00, 1'b1, 1'b1, ST_SHORT}
  };

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  sfd_in_t  in_data  = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  sfd_out_t out_data_o;

  logic        hold_go  = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned in_idle_pct = 0;
  int unsigned stall_pct   = 0;
  int unsigned acc_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned err_cnt = 0;

  sfd_out_t want_q [$];

  // predictor state for the frame in progress
  logic [15:0] at_pos;
  logic [63:0] hdr_id;
  logic [63:0] hdr_time;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_len;
  logic [15:0] trl_drop;
  logic [7:0]  trl_frames;
  logic [7:0]  trl_flags;
  logic        marks_ok;

  stream_frame_decoder #(
    .BatchDataMax(BATCH_MAX)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_frame();
    at_pos     = '0;
    hdr_id     = '0;
    hdr_time   = '0;
    hdr_seq    = '0;
    hdr_len    = '0;
    trl_drop   = '0;
    trl_frames = '0;
    trl_flags  = '0;
    marks_ok   = 1'b1;
  endtask

  task automatic decode_byte(input sfd_in_t beat, output sfd_out_t res);
    logic [63:0] pos_w;
    logic [63:0] win_end;
    logic [63:0] ofs;
    logic [63:0] cnt;
    res     = '0;
    pos_w   = 64'(at_pos);
    win_end = 64'(HdrBytes) + 64'(hdr_len);
    if (at_pos < IdEnd) begin
      hdr_id = {hdr_id[55:0], beat.body_byte};
    end else if (at_pos < TimeEnd) begin
      hdr_time = {hdr_time[55:0], beat.body_byte};
    end else if (at_pos < SeqEnd) begin
      hdr_seq = {hdr_seq[23:0], beat.body_byte};
    end else if (at_pos < HdrBytes) begin
      hdr_len = {hdr_len[23:0], beat.body_byte};
    end else if (pos_w < win_end) begin
      res.payload_valid = 1'b1;
    end else begin
      // trailer offsets, anything past the marker is dropped
      ofs = pos_w - win_end;
      if (ofs < 2) begin
        trl_drop = {trl_drop[7:0], beat.body_byte};
      end else if (ofs == 2) begin
        trl_frames = beat.body_byte;
      end else if (ofs == 3) begin
        trl_flags = beat.body_byte;
      end else if (ofs < TrlBytes && beat.body_byte != MarkChar) begin
        marks_ok = 1'b0;
      end
    end
    res.payload_byte = beat.body_byte;
    cnt = pos_w + 64'd1;
    if (at_pos != PosTop) at_pos = at_pos + 16'd1;
    if (beat.last_byte) begin
      res.frame_done = 1'b1;
      if (cnt < MinFrame) begin
        res.status = ST_SHORT;
      end else if (hdr_len > BATCH_MAX || cnt != 64'(MinFrame) + 64'(hdr_len)) begin
        res.status = ST_BAD_LEN;
      end else if (!marks_ok) begin
        res.status = ST_BAD_MARK;
      end else begin
        res.status         = ST_OK;
        res.frame_id       = hdr_id;
        res.time_stamp     = hdr_time;
        res.seq_number     = hdr_seq;
        res.payload_length = hdr_len;
        res.dropped_count  = {trl_flags[7:3], trl_drop};
        res.batch_frames   = trl_frames;
        res.last_type      = trl_flags[2:0];
      end
      clear_frame();
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return MarkChar;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one beat, hold it through stalls, queue its expected result on acceptance
  task automatic send_byte(input sfd_in_t beat, input logic typed, input sfd_out_t typed_res);
    sfd_out_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall_o);
    decode_byte(beat, res);
    want_q.push_back(typed ? typed_res : res);
    acc_cnt++;
  endtask

  // header, payload, trailer; bad_mark corrupts marker bytes, adjust appends or cuts bytes
  task automatic send_frame(input logic [31:0] decl_len, input int unsigned pay_cnt,
                            input logic [3:0] bad_mark, input int adjust);
    logic [7:0] body [$];
    logic [7:0] b;
    sfd_in_t    beat;
    int         n;
    for (int i = 0; i < 20; i++) body.push_back(rand_byte());
    for (int i = 3; i >= 0; i--) body.push_back(decl_len[i*8 +: 8]);
    for (int i = 0; i < pay_cnt; i++) body.push_back(8'($urandom_range(255)));
    for (int i = 0; i < 4; i++) body.push_back(rand_byte());
    for (int i = 0; i < 4; i++) begin
      if (bad_mark[i]) begin
        b = 8'($urandom_range(254));
        if (b >= MarkChar) b = b + 8'd1;
        body.push_back(b);
      end else begin
        body.push_back(MarkChar);
      end
    end
    if (adjust > 0) begin
      repeat (adjust) body.push_back(rand_byte());
    end else begin
      repeat (-adjust) if (body.size() > 1) void'(body.pop_back());
    end
    n = body.size();
    for (int i = 0; i < n; i++) begin
      beat.body_byte = body[i];
      beat.last_byte = (i == n - 1);
      send_byte(beat, 1'b0, '0);
    end
  endtask

  // nearly half well formed frames with random content, the rest broken frames and noise
  task automatic run_frames(input int unsigned target);
    int unsigned start;
    int unsigned r;
    int unsigned plen;
    int unsigned n;
    int unsigned k;
    logic [31:0] big_len;
    sfd_in_t     beat;
    start = acc_cnt;
    while (acc_cnt - start < target) begin
      r    = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(24);
      k    = $urandom_range(1, 4);
      if (r < 48) begin
        send_frame(plen, plen, 4'h0, 0);
      end else if (r < 60) begin
        send_frame(plen, plen, 4'($urandom_range(1, 15)), 0);
      end else if (r < 68) begin
        send_frame(plen, plen, 4'($urandom_range(15)), $urandom_range(1, 6));
      end else if (r < 78) begin
        send_frame(plen, plen, 4'h0, -int'($urandom_range(1, plen + 31)));
      end else if (r < 85) begin
        // declared length off from the real one, trailer read at the wrong place
        send_frame(plen + k, plen, 4'h0, k);
      end else if (r < 92) begin
        big_len = $urandom;
        if (big_len <= BATCH_MAX) big_len = big_len + BATCH_MAX + 1;
        if ($urandom_range(3) == 0) big_len = 32'hFFFF_FFFF;
        send_frame(big_len, $urandom_range(12), 4'($urandom_range(15)), 0);
      end else begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          beat.body_byte = 8'($urandom_range(255));
          beat.last_byte = (i == n - 1);
          send_byte(beat, 1'b0, '0);
        end
      end
    end
  endtask

  function automatic void show_field(input string name, input logic [63:0] w,
                                     input logic [63:0] g);
    if (w !== g) $display("  %s expected %0h got %0h", name, w, g);
  endfunction

  task automatic compare_result(input sfd_out_t got);
    sfd_out_t w;
    if (want_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= SHOW_MAX) $display("result beat %0d with nothing expected: %h", res_cnt, got);
    end else begin
      w = want_q.pop_front();
      if (got !== w) begin
        err_cnt++;
        if (err_cnt <= SHOW_MAX) begin
          $display("mismatch on result beat %0d", res_cnt);
          show_field("payload_valid", w.payload_valid, got.payload_valid);
          show_field("payload_byte", w.payload_byte, got.payload_byte);
          show_field("frame_done", w.frame_done, got.frame_done);
          show_field("status", w.status, got.status);
          show_field("frame_id", w.frame_id, got.frame_id);
          show_field("time_stamp", w.time_stamp, got.time_stamp);
          show_field("seq_number", w.seq_number, got.seq_number);
          show_field("payload_length", w.payload_length, got.payload_length);
          show_field("dropped_count", w.dropped_count, got.dropped_count);
          show_field("batch_frames", w.batch_frames, got.batch_frames);
          show_field("last_type", w.last_type, got.last_type);
        end
      end
    end
    res_cnt++;
  endtask

  // result side: check accepted beats, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) compare_result(out_data_o);
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off so the decoder fills up and pushes back on its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    sfd_out_t typed_res;
    sfd_in_t  beat;
    clear_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int i = 0; i < DIR_N; i++) begin
      beat.body_byte           = DIR_TAB[i].data;
      beat.last_byte           = DIR_TAB[i].last;
      typed_res                = '0;
      typed_res.payload_byte   = DIR_TAB[i].data;
      typed_res.frame_done     = DIR_TAB[i].last;
      typed_res.status         = DIR_TAB[i].st;
      send_byte(beat, DIR_TAB[i].typed, typed_res);
    end

    // no idling, with the long hold-off at the start
    hold_go = 1'b1;
    send_frame(0, 0, 4'h0, -1);
    send_frame(0, 0, 4'h0, 0);
    send_frame(0, 0, 4'hF, 0);
    run_frames(PHASE_ITEMS);

    in_idle_pct = 80;
    stall_pct   = 0;
    run_frames(PHASE_ITEMS);

    in_idle_pct = 0;
    stall_pct   = 80;
    run_frames(PHASE_ITEMS);

    in_idle_pct = 31;
    stall_pct   = 31;
    run_frames(PHASE_ITEMS);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("stream_frame_decoder test passed");
    end else begin
      $display("stream_frame_decoder test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("stream_frame_decoder test failed");
    $finish;
  end

endmodule
